// ===== src/fbca_pkg.sv =====
// ---------------------------------------------------------------------------
// fbca_pkg: shared types and constants of the block chain allocator
// Sizes, command and status codes, controller-to-datapath command and status.
// ---------------------------------------------------------------------------
package fbca_pkg;

  localparam int NUM_BLOCKS       = 256;
  localparam int ROOT_ENTRIES     = 16;
  localparam int FIRST_DATA_BLOCK = 15;

  localparam int CMD_W  = 3;
  localparam int KEY_W  = 48;
  localparam int BLK_W  = 8;
  localparam int ST_W   = 3;
  localparam int SLOT_W = 4;
  localparam int STEP_W = 9;   // counts walk steps up to NUM_BLOCKS
  localparam int IN_W   = 64;
  localparam int OUT_W  = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [ST_W-1:0] ST_EXISTS      = 3'd2;
  localparam logic [ST_W-1:0] ST_DIR_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_EMPTY   = 3'd4;
  localparam logic [ST_W-1:0] ST_NO_SPACE    = 3'd5;
  localparam logic [ST_W-1:0] ST_NOT_IN_FILE = 3'd6;

  // datapath operations
  localparam logic [4:0] OP_NONE          = 5'd0;
  localparam logic [4:0] OP_LOAD          = 5'd1;
  localparam logic [4:0] OP_SCAN          = 5'd2;
  localparam logic [4:0] OP_INIT          = 5'd3;
  localparam logic [4:0] OP_CREATE        = 5'd4;
  localparam logic [4:0] OP_REMOVE        = 5'd5;
  localparam logic [4:0] OP_GOT           = 5'd6;
  localparam logic [4:0] OP_HEAD_Q        = 5'd7;
  localparam logic [4:0] OP_CLR_GOT       = 5'd8;
  localparam logic [4:0] OP_SET_FIRST_GOT = 5'd9;
  localparam logic [4:0] OP_WALK_START    = 5'd10;
  localparam logic [4:0] OP_WALK          = 5'd11;
  localparam logic [4:0] OP_TAIL_WR       = 5'd12;
  localparam logic [4:0] OP_SET_FIRST_VB  = 5'd13;
  localparam logic [4:0] OP_PREV_WR       = 5'd14;
  localparam logic [4:0] OP_BN_WR         = 5'd15;
  localparam logic [4:0] OP_HEAD_BN       = 5'd16;

  // table read address select
  localparam logic [1:0] RA_ZERO  = 2'd0;
  localparam logic [1:0] RA_Q     = 2'd1;
  localparam logic [1:0] RA_FIRST = 2'd2;

  // result block select
  localparam logic [1:0] BS_NONE  = 2'd0;
  localparam logic [1:0] BS_FIRST = 2'd1;
  localparam logic [1:0] BS_GOT   = 2'd2;
  localparam logic [1:0] BS_Q     = 2'd3;

  typedef struct packed {
    logic [4:0]      op;
    logic [1:0]      rsel;
    logic            res_we;
    logic [ST_W-1:0] st;
    logic [1:0]      bsel;
    logic            out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic found;
    logic has_free;
    logic first_zero;
    logic first_is_bn;
    logic bn_zero;
    logic q_zero;
    logic q_is_bn;
    logic scan_last;
    logic init_last;
    logic steps_last;
    logic steps_full;
    logic out_free;
  } dp_stat_t;

  // reset content of the allocation table
  function automatic logic [BLK_W-1:0] table_init(input logic [BLK_W-1:0] idx);
    logic [BLK_W-1:0] val;
    val = '0;
    if (idx == '0)
      val = BLK_W'(FIRST_DATA_BLOCK);
    else if (idx >= BLK_W'(FIRST_DATA_BLOCK) && idx < BLK_W'(NUM_BLOCKS - 1))
      val = idx + 1'b1;
    return val;
  endfunction

endpackage

// ===== src/fbca_datapath.sv =====
// ---------------------------------------------------------------------------
// fbca_datapath: directory, allocation table and result register
// Executes one operation per cycle as commanded by the controller.
// ---------------------------------------------------------------------------
module fbca_datapath import fbca_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  // latched transaction fields
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [BLK_W-1:0]  bn_r;

  // directory
  logic [KEY_W-1:0]  dir_name_r  [ROOT_ENTRIES];
  logic              dir_valid_r [ROOT_ENTRIES];
  logic [BLK_W-1:0]  dir_first_r [ROOT_ENTRIES];

  // search results
  logic [SLOT_W-1:0] scan_idx_r, slot_r, free_r;
  logic              found_r, has_free_r;

  // walk and allocation registers
  logic [BLK_W-1:0]  got_r, ptr_r, vb_r, init_idx_r;
  logic [STEP_W-1:0] steps_r;

  // allocation table
  logic [BLK_W-1:0]  fat_mem [NUM_BLOCKS];
  logic [BLK_W-1:0]  q_r;
  logic [BLK_W-1:0]  rd_addr, wr_addr, wr_data;
  logic              wr_en;

  // result and output registers
  logic [ST_W-1:0]   res_st_r;
  logic [BLK_W-1:0]  res_blk_r, res_blk_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [BLK_W-1:0]  first_cur;
  logic              name_hit;

  assign first_cur = dir_first_r[slot_r];
  assign name_hit  = dir_valid_r[scan_idx_r] && (dir_name_r[scan_idx_r] == key_r);

  // status to the controller
  always_comb begin
    stat.cmd         = cmd_r;
    stat.found       = found_r;
    stat.has_free    = has_free_r;
    stat.first_zero  = (first_cur == '0);
    stat.first_is_bn = (first_cur == bn_r);
    stat.bn_zero     = (bn_r == '0);
    stat.q_zero      = (q_r == '0);
    stat.q_is_bn     = (q_r == bn_r);
    stat.scan_last   = (scan_idx_r == SLOT_W'(ROOT_ENTRIES - 1));
    stat.init_last   = (init_idx_r == BLK_W'(NUM_BLOCKS - 1));
    stat.steps_last  = (steps_r == STEP_W'(NUM_BLOCKS - 1));
    stat.steps_full  = (steps_r == STEP_W'(NUM_BLOCKS));
    stat.out_free    = !out_valid_r || out_tready;
  end

  // table read address
  always_comb begin
    case (cmd.rsel)
      RA_Q:     rd_addr = q_r;
      RA_FIRST: rd_addr = first_cur;
      default:  rd_addr = '0;
    endcase
  end

  // table write port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    case (cmd.op)
      OP_INIT: begin
        wr_addr = init_idx_r;
        wr_data = table_init(init_idx_r);
      end
      OP_HEAD_Q:   wr_data = q_r;
      OP_CLR_GOT:  wr_addr = got_r;
      OP_TAIL_WR: begin
        wr_addr = ptr_r;
        wr_data = got_r;
      end
      OP_PREV_WR: begin
        wr_addr = ptr_r;
        wr_data = vb_r;
      end
      OP_BN_WR: begin
        wr_addr = bn_r;
        wr_data = q_r;
      end
      OP_HEAD_BN:  wr_data = bn_r;
      default:     wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      fat_mem[wr_addr] <= wr_data;
    q_r <= fat_mem[rd_addr];
  end

  // transaction fields, search, walk registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r      <= in_tdata[2:0];
        key_r      <= in_tdata[50:3];
        bn_r       <= in_tdata[58:51];
        scan_idx_r <= '0;
        found_r    <= 1'b0;
        has_free_r <= 1'b0;
      end
      OP_SCAN: begin
        if (name_hit && !found_r) begin
          found_r <= 1'b1;
          slot_r  <= scan_idx_r;
        end
        if (!dir_valid_r[scan_idx_r] && !has_free_r) begin
          has_free_r <= 1'b1;
          free_r     <= scan_idx_r;
        end
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      OP_GOT: got_r <= q_r;
      OP_WALK_START: begin
        ptr_r   <= first_cur;
        steps_r <= '0;
        vb_r    <= q_r;
      end
      OP_WALK: begin
        ptr_r   <= q_r;
        steps_r <= steps_r + 1'b1;
      end
      default: ;
    endcase
  end

  // directory updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        dir_valid_r[i] <= 1'b0;
        dir_first_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_CREATE: begin
          dir_valid_r[free_r] <= 1'b1;
          dir_first_r[free_r] <= '0;
        end
        OP_REMOVE:        dir_valid_r[slot_r] <= 1'b0;
        OP_SET_FIRST_GOT: dir_first_r[slot_r] <= got_r;
        OP_SET_FIRST_VB:  dir_first_r[slot_r] <= q_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CREATE)
      dir_name_r[free_r] <= key_r;
  end

  // table clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n)
      init_idx_r <= '0;
    else if (cmd.op == OP_INIT)
      init_idx_r <= init_idx_r + 1'b1;
  end

  // result register
  always_comb begin
    case (cmd.bsel)
      BS_FIRST: res_blk_nxt = first_cur;
      BS_GOT:   res_blk_nxt = got_r;
      BS_Q:     res_blk_nxt = q_r;
      default:  res_blk_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_st_r  <= cmd.st;
      res_blk_r <= res_blk_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {5'b0, res_blk_r, res_st_r};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/fbca_ctrl.sv =====
// ---------------------------------------------------------------------------
// fbca_ctrl: command sequencer
// Clears the table after reset, then runs directory search and chain walks.
// ---------------------------------------------------------------------------
module fbca_ctrl import fbca_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DISP   = 4'd3;
  localparam logic [3:0] S_A_GOT  = 4'd4;
  localparam logic [3:0] S_A_NXT  = 4'd5;
  localparam logic [3:0] S_A_CLR  = 4'd6;
  localparam logic [3:0] S_A_LINK = 4'd7;
  localparam logic [3:0] S_A_WALK = 4'd8;
  localparam logic [3:0] S_C_WALK = 4'd9;
  localparam logic [3:0] S_HITQ   = 4'd10;
  localparam logic [3:0] S_D_PW   = 4'd11;
  localparam logic [3:0] S_D_RD0  = 4'd12;
  localparam logic [3:0] S_D_FIN  = 4'd13;
  localparam logic [3:0] S_D_HEAD = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= S_INIT;
    else
      state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and datapath command
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.rsel     = RA_ZERO;
    cmd.st       = ST_OK;
    cmd.bsel     = BS_NONE;
    case (state_r)
      S_INIT: begin
        cmd.op = OP_INIT;
        if (stat.init_last)
          state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_last)
          state_nxt = S_DISP;
      end
      S_DISP: begin
        // default: finish with the result set here
        cmd.res_we = 1'b1;
        state_nxt  = S_OUT;
        case (stat.cmd)
          CMD_CREATE: begin
            if (stat.found)
              cmd.st = ST_EXISTS;
            else if (stat.has_free)
              cmd.op = OP_CREATE;
            else
              cmd.st = ST_DIR_FULL;
          end
          CMD_REMOVE: begin
            if (!stat.found)
              cmd.st = ST_NOT_FOUND;
            else if (!stat.first_zero)
              cmd.st = ST_NOT_EMPTY;
            else
              cmd.op = OP_REMOVE;
          end
          CMD_FIRST: begin
            if (!stat.found)
              cmd.st = ST_NOT_FOUND;
            else
              cmd.bsel = BS_FIRST;
          end
          CMD_APPEND: begin
            if (!stat.found) begin
              cmd.st = ST_NOT_FOUND;
            end else begin
              // table head read issued now
              cmd.res_we = 1'b0;
              state_nxt  = S_A_GOT;
            end
          end
          CMD_DELETE, CMD_NEXT: begin
            if (!stat.found) begin
              cmd.st = ST_NOT_FOUND;
            end else if (stat.bn_zero || stat.first_zero) begin
              cmd.st = ST_NOT_IN_FILE;
            end else if (stat.first_is_bn) begin
              cmd.res_we = 1'b0;
              cmd.rsel   = RA_FIRST;
              state_nxt  = S_HITQ;
            end else begin
              cmd.res_we = 1'b0;
              cmd.op     = OP_WALK_START;
              cmd.rsel   = RA_FIRST;
              state_nxt  = S_C_WALK;
            end
          end
          default: ;
        endcase
      end
      // append: pop the free-list head
      S_A_GOT: begin
        if (stat.q_zero) begin
          cmd.res_we = 1'b1;
          cmd.st     = ST_NO_SPACE;
          state_nxt  = S_OUT;
        end else begin
          cmd.op    = OP_GOT;
          cmd.rsel  = RA_Q;
          state_nxt = S_A_NXT;
        end
      end
      S_A_NXT: begin
        cmd.op    = OP_HEAD_Q;
        state_nxt = S_A_CLR;
      end
      S_A_CLR: begin
        cmd.op    = OP_CLR_GOT;
        state_nxt = S_A_LINK;
      end
      S_A_LINK: begin
        if (stat.first_zero) begin
          cmd.op     = OP_SET_FIRST_GOT;
          cmd.res_we = 1'b1;
          cmd.bsel   = BS_GOT;
          state_nxt  = S_OUT;
        end else begin
          cmd.op    = OP_WALK_START;
          cmd.rsel  = RA_FIRST;
          state_nxt = S_A_WALK;
        end
      end
      // append: find the tail, one link per cycle
      S_A_WALK: begin
        if (stat.q_zero || stat.steps_full) begin
          cmd.op     = OP_TAIL_WR;
          cmd.res_we = 1'b1;
          cmd.bsel   = BS_GOT;
          state_nxt  = S_OUT;
        end else begin
          cmd.op   = OP_WALK;
          cmd.rsel = RA_Q;
        end
      end
      // membership walk for delete and next
      S_C_WALK: begin
        if (stat.q_zero || stat.steps_last) begin
          cmd.res_we = 1'b1;
          cmd.st     = ST_NOT_IN_FILE;
          state_nxt  = S_OUT;
        end else if (stat.q_is_bn) begin
          cmd.rsel  = RA_Q;
          state_nxt = S_HITQ;
        end else begin
          cmd.op   = OP_WALK;
          cmd.rsel = RA_Q;
        end
      end
      // successor of the block is on the read port
      S_HITQ: begin
        if (stat.cmd == CMD_NEXT) begin
          cmd.res_we = 1'b1;
          cmd.bsel   = BS_Q;
          state_nxt  = S_OUT;
        end else if (stat.first_is_bn) begin
          cmd.op    = OP_SET_FIRST_VB;
          state_nxt = S_D_RD0;
        end else begin
          cmd.op    = OP_WALK_START;
          cmd.rsel  = RA_FIRST;
          state_nxt = S_D_PW;
        end
      end
      // delete: find the predecessor and bypass the block
      S_D_PW: begin
        if (stat.q_is_bn || stat.steps_full) begin
          cmd.op    = OP_PREV_WR;
          state_nxt = S_D_RD0;
        end else begin
          cmd.op   = OP_WALK;
          cmd.rsel = RA_Q;
        end
      end
      S_D_RD0: state_nxt = S_D_FIN;
      S_D_FIN: begin
        cmd.op    = OP_BN_WR;
        state_nxt = S_D_HEAD;
      end
      S_D_HEAD: begin
        cmd.op     = OP_HEAD_BN;
        cmd.res_we = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// ===== src/fat_block_chain_allocator.sv =====
// ---------------------------------------------------------------------------
// fat_block_chain_allocator: root directory and linked block allocation table
// Create/remove files, append/delete blocks, next and first block lookups.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata: cmd[2:0], file_key[50:3], block_num[58:51]
//  out_    | master    | tdata: status[2:0], block_out[10:3]
//
// A transaction passes through accept, a 16-slot search, dispatch and hand-over;
// append and delete add further states, plus chain walks at one table entry per
// cycle for append, next and delete.
// After reset a clearing pass over the whole table loads the free chain; in_tready is
// low meanwhile. A stalled result waits in the output register; the next
// transaction is taken meanwhile and waits only to hand over its result.
module fat_block_chain_allocator import fbca_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cmd, file_key, block_num
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, block_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fbca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fbca_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/fbca_checker.sv =====
// ---------------------------------------------------------------------------
// fbca_checker: port-level checks of the allocator
// Result encoding and handshake behaviour seen at the top-level ports.
// ---------------------------------------------------------------------------
module fbca_checker import fbca_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // only defined status codes, and zero padding
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7 && out_tdata[15:11] == 5'd0)
    else $error("bad status code or padding");

  // failed commands return no block
  a_err_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[10:3] == 8'd0)
    else $error("block returned with error status");

  // table clearing pass follows reset
  a_init: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken before clearing pass");

endmodule

bind fat_block_chain_allocator fbca_checker u_fbca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: block chain allocator stream test
// Directed and random command transactions with random idling on both
// channels; a scoreboard class predicts each result from its own copy of the
// directory and allocation table and checks the results in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import fbca_pkg::*;

  // expected result of one command
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] blk;
  } fat_result_t;

  // predictor and store of pending results
  class fat_scoreboard;
    logic [KEY_W-1:0] names [ROOT_ENTRIES];
    bit               used  [ROOT_ENTRIES];
    logic [BLK_W-1:0] heads [ROOT_ENTRIES];
    logic [BLK_W-1:0] links [NUM_BLOCKS];
    fat_result_t      pending [$];
    int               mismatches;
    int               checked;

    function new();
      for (int i = 0; i < ROOT_ENTRIES; i++) begin
        used[i]  = 0;
        heads[i] = '0;
        names[i] = '0;
      end
      for (int i = 0; i < NUM_BLOCKS; i++)
        links[i] = '0;
      links[0] = BLK_W'(FIRST_DATA_BLOCK);
      for (int i = FIRST_DATA_BLOCK; i < NUM_BLOCKS - 1; i++)
        links[i] = BLK_W'(i + 1);
      mismatches = 0;
      checked    = 0;
    endfunction

    function int lookup(logic [KEY_W-1:0] key);
      for (int i = 0; i < ROOT_ENTRIES; i++)
        if (used[i] && names[i] == key) return i;
      return -1;
    endfunction

    function bit in_chain(logic [BLK_W-1:0] first, logic [BLK_W-1:0] target);
      logic [BLK_W-1:0] b;
      int n;
      b = first;
      n = 0;
      while (b != 0 && n < NUM_BLOCKS) begin
        if (b == target) return 1;
        b = links[b];
        n++;
      end
      return 0;
    endfunction

    // note one accepted command and predict its result
    function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [BLK_W-1:0] bn);
      fat_result_t r;
      logic [BLK_W-1:0] got, walk;
      int s, n;
      r = '{status: ST_OK, blk: '0};
      s = lookup(key);
      case (cmd)
        CMD_CREATE: begin
          if (s >= 0) r.status = ST_EXISTS;
          else begin
            r.status = ST_DIR_FULL;
            for (int i = 0; i < ROOT_ENTRIES; i++)
              if (!used[i]) begin
                used[i]  = 1;
                names[i] = key;
                heads[i] = '0;
                r.status = ST_OK;
                break;
              end
          end
        end
        CMD_REMOVE: begin
          if (s < 0) r.status = ST_NOT_FOUND;
          else if (heads[s] != 0) r.status = ST_NOT_EMPTY;
          else used[s] = 0;
        end
        CMD_APPEND: begin
          if (s < 0) r.status = ST_NOT_FOUND;
          else if (links[0] == 0) r.status = ST_NO_SPACE;
          else begin
            got = links[0];
            links[0]   = links[got];
            links[got] = '0;
            if (heads[s] == 0) heads[s] = got;
            else begin
              walk = heads[s];
              n = 0;
              while (links[walk] != 0 && n < NUM_BLOCKS) begin
                walk = links[walk];
                n++;
              end
              links[walk] = got;
            end
            r.blk = got;
          end
        end
        CMD_DELETE: begin
          if (s < 0) r.status = ST_NOT_FOUND;
          else if (bn == 0 || !in_chain(heads[s], bn)) r.status = ST_NOT_IN_FILE;
          else begin
            if (heads[s] == bn) heads[s] = links[bn];
            else begin
              walk = heads[s];
              n = 0;
              while (links[walk] != bn && n < NUM_BLOCKS) begin
                walk = links[walk];
                n++;
              end
              links[walk] = links[bn];
            end
            links[bn] = links[0];
            links[0]  = bn;
          end
        end
        CMD_NEXT: begin
          if (s < 0) r.status = ST_NOT_FOUND;
          else if (bn == 0 || !in_chain(heads[s], bn)) r.status = ST_NOT_IN_FILE;
          else r.blk = links[bn];
        end
        CMD_FIRST: begin
          if (s < 0) r.status = ST_NOT_FOUND;
          else r.blk = heads[s];
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    // compare one result with the oldest expectation
    function void check_result(logic [OUT_W-1:0] data);
      fat_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      want = pending.pop_front();
      if (data[2:0] !== want.status || data[10:3] !== want.blk) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected status %0d block %0d, got status %0d block %0d",
                   checked, want.status, want.blk, data[2:0], data[10:3]);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  fat_scoreboard sb;
  logic [KEY_W-1:0] key_pool [8];
  int            blk_cycle;

  fat_block_chain_allocator dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // one command transaction after a random gap; tvalid stays up between
  // back-to-back transactions
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                              logic [BLK_W-1:0] bn);
    int gap;
    gap = (blk_cycle % 200 < 40) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, bn, key, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, key, bn);
  endtask

  // blocks that the file behind a key may well hold
  function automatic logic [BLK_W-1:0] pick_block();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return BLK_W'($urandom_range(0, 255));
    if (p == 1) return '0;
    return BLK_W'($urandom_range(FIRST_DATA_BLOCK, FIRST_DATA_BLOCK + 60));
  endfunction

  // receiver: random stall per result, stretches with none
  always @(posedge clk) begin
    static int wait_left = 0;
    blk_cycle <= blk_cycle + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        wait_left = (blk_cycle % 300 < 60) ? 0 : $urandom_range(0, 11);
      end
      if (wait_left > 0) begin
        wait_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int drain;
    sb = new();
    blk_cycle = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    out_tready = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = {KEY_W{1'b1}};
    for (int i = 2; i < 8; i++) key_pool[i] = KEY_W'({$urandom, $urandom});
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, error cases
    send_command(CMD_FIRST,  key_pool[0], 8'd0);
    send_command(CMD_REMOVE, key_pool[0], 8'd0);
    send_command(CMD_APPEND, key_pool[0], 8'd0);
    send_command(CMD_CREATE, key_pool[0], 8'd0);
    send_command(CMD_CREATE, key_pool[0], 8'd0);
    send_command(CMD_CREATE, key_pool[1], 8'hff);
    send_command(CMD_APPEND, key_pool[1], 8'd0);
    send_command(CMD_APPEND, key_pool[1], 8'd0);
    send_command(CMD_APPEND, key_pool[1], 8'd0);
    send_command(CMD_NEXT,   key_pool[1], 8'd15);
    send_command(CMD_NEXT,   key_pool[1], 8'd0);
    send_command(CMD_NEXT,   key_pool[1], 8'hff);
    send_command(CMD_REMOVE, key_pool[1], 8'd0);
    send_command(CMD_DELETE, key_pool[1], 8'd16);
    send_command(CMD_DELETE, key_pool[1], 8'd16);
    send_command(CMD_DELETE, key_pool[1], 8'd15);
    send_command(CMD_FIRST,  key_pool[1], 8'd0);
    send_command(3'd6,       key_pool[1], 8'd7);
    send_command(3'd7,       key_pool[0], 8'd0);
    // fill the directory, then two too many
    for (int i = 0; i < ROOT_ENTRIES; i++)
      send_command(CMD_CREATE, KEY_W'({$urandom, $urandom}), 8'd0);

    // random: mostly known names, appends outweigh deletes early on
    for (int i = 0; i < 1100; i++) begin
      case ($urandom_range(0, 19))
        0, 1:           cmd = CMD_CREATE;
        2:              cmd = CMD_REMOVE;
        3, 4, 5, 6, 7:  cmd = CMD_APPEND;
        8, 9, 10, 11:   cmd = CMD_DELETE;
        12, 13, 14:     cmd = CMD_NEXT;
        15, 16:         cmd = CMD_FIRST;
        17:             cmd = 3'($urandom_range(6, 7));
        default:        cmd = 3'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 9) == 0) key = KEY_W'({$urandom, $urandom});
      else key = key_pool[$urandom_range(0, 7)];
      // phase of heavy deletes empties files so removes succeed
      if (i > 700 && cmd == CMD_APPEND && $urandom_range(0, 1)) cmd = CMD_DELETE;
      send_command(cmd, key, pick_block());
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (sb.pending.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (600) @(posedge clk);
    $display("Ran %0d commands over all codes, full directory and deep chains;",
             1100 + 35);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #60_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
src/fbca_pkg.sv
src/fbca_datapath.sv
src/fbca_ctrl.sv
src/fat_block_chain_allocator.sv
src/fbca_checker.sv
bench/testbench.sv
